/* hdl/mwd_pkg.sv */
// Shared constants and types for the multiword by word divider.
package mwd_pkg;

    // Field widths on the ports
    localparam int DATA_W = 64;
    localparam int CFG_W  = 64;
    localparam int ADDR_W = 4;

    // Arithmetic word width, 8 to 64
    localparam int WORD_BITS = 64;
    localparam int CNT_W     = $clog2(WORD_BITS);

    // Register index taken from paddr[3]
    localparam logic REG_DIVISOR = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PRE  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    typedef struct packed {
        logic                 qbit;
        logic [WORD_BITS-1:0] rem;
    } step_res_t;

endpackage

/* hdl/multiword_by_word_divider_top.sv */
// Multiword by word divider: streaming short division with an APB divisor register.
//
//  channel  | dir | signals                         | contents
//  ---------+-----+---------------------------------+--------------------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata s_tlast | limb, last_limb on tlast
//  m_*      | out | m_tvalid m_tready m_tdata m_tlast | quotient, remainder, last, zero flag
//  apb      | in  | psel penable pwrite paddr pwdata  | divisor at address 0
//
// A limb is accepted only in the idle state and then divided by WORD_BITS steps, one
// step a cycle of the shared subtract unit; the finish state then loads the output register.
// If the carried remainder is at or above the divisor, it is first reduced by another
// WORD_BITS steps on the same unit; a zero divisor goes straight to the finish state.
// Reset clears the sequencer, the output valid flag and the carried remainder; divisor is 1.
// While a result waits on m_tready the unit holds in its finish state.
module multiword_by_word_divider_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // s_tdata: limb[63:0]
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mwd_pkg::DATA_W-1:0]  s_tdata,
    input  logic                        s_tlast,
    // m_tdata: quotient_limb[63:0], final_remainder[127:64]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [2*mwd_pkg::DATA_W-1:0] m_tdata,
    output logic                        m_tlast,
    // m_tuser: divide_by_zero[0]
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mwd_pkg::ADDR_W-1:0]  paddr,
    input  logic [mwd_pkg::CFG_W-1:0]   pwdata,
    output logic [mwd_pkg::CFG_W-1:0]   prdata,
    output logic                        pready
);
    import mwd_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CFG_W-1:0]     divisor_reg, divisor_next;
    logic [WORD_BITS-1:0] rr_reg, rr_next;
    logic                 out_valid_reg, out_valid_next;

    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] shift_reg, shift_next;
    logic [WORD_BITS-1:0] limb_reg, limb_next;
    logic                 last_reg, last_next;
    logic                 dbz_reg, dbz_next;
    logic [DATA_W-1:0]    out_quot_reg, out_quot_next;
    logic [DATA_W-1:0]    out_rem_reg, out_rem_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_dbz_reg, out_dbz_next;

    logic [WORD_BITS-1:0] d;
    logic                 cfg_write;
    logic                 s_fire;
    logic                 out_load;
    step_res_t            step;

    assign d         = divisor_reg[WORD_BITS-1:0];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[3] == REG_DIVISOR) ? divisor_reg : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rem_reg, out_quot_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_dbz_reg;

    mwd_div_step u_step (
        .rem_in  (rem_reg),
        .bit_in  (shift_reg[WORD_BITS-1]),
        .divisor (d),
        .res     (step)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        divisor_next   = divisor_reg;
        rr_next        = rr_reg;
        out_valid_next = out_valid_reg;
        rem_next       = rem_reg;
        shift_next     = shift_reg;
        limb_next      = limb_reg;
        last_next      = last_reg;
        dbz_next       = dbz_reg;
        out_quot_next  = out_quot_reg;
        out_rem_next   = out_rem_reg;
        out_last_next  = out_last_reg;
        out_dbz_next   = out_dbz_reg;

        if (cfg_write && (paddr[3] == REG_DIVISOR))
        begin
            divisor_next = pwdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    last_next = s_tlast;
                    limb_next = s_tdata[WORD_BITS-1:0];
                    dbz_next  = (d == '0);
                    cnt_next  = CNT_LAST;
                    priority if (d == '0)
                    begin
                        shift_next = '0;
                        rem_next   = '0;
                        if (s_tlast)
                        begin
                            rr_next = '0;
                        end
                        state_next = ST_FIN;
                    end
                    else if (rr_reg >= d)
                    begin
                        // Reduce the carried remainder before the limb itself
                        rem_next   = '0;
                        shift_next = rr_reg;
                        state_next = ST_PRE;
                    end
                    else
                    begin
                        rem_next   = rr_reg;
                        shift_next = s_tdata[WORD_BITS-1:0];
                        state_next = ST_DIV;
                    end
                end
            end
            ST_PRE:
            begin
                rem_next   = step.rem;
                shift_next = {shift_reg[WORD_BITS-2:0], step.qbit};
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    // Drop the quotient of the reduction, start on the limb
                    shift_next = limb_reg;
                    cnt_next   = CNT_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next   = step.rem;
                shift_next = {shift_reg[WORD_BITS-2:0], step.qbit};
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rr_next    = last_reg ? '0 : step.rem;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_quot_next  = DATA_W'(shift_reg);
            out_rem_next   = last_reg ? DATA_W'(rem_reg) : '0;
            out_last_next  = last_reg;
            out_dbz_next   = dbz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            divisor_reg   <= CFG_W'(1);
            rr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            divisor_reg   <= divisor_next;
            rr_reg        <= rr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        shift_reg    <= shift_next;
        limb_reg     <= limb_next;
        last_reg     <= last_next;
        dbz_reg      <= dbz_next;
        out_quot_reg <= out_quot_next;
        out_rem_reg  <= out_rem_next;
        out_last_reg <= out_last_next;
        out_dbz_reg  <= out_dbz_next;
    end

`ifndef SYNTHESIS
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_dbz_reg) |-> (out_quot_reg == '0 && out_rem_reg == '0))
        else $error("zero divisor result carries nonzero data");

    a_rem_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_rem_reg == '0))
        else $error("final remainder set on a result that is not last");

    a_dbz_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && d == '0 && s_tlast) |=> (rr_reg == '0))
        else $error("carried remainder not cleared after last limb");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finish did not load the output register");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("accepted an item while a division is in flight");
`endif

endmodule

/* hdl/mwd_div_step.sv */
// One restoring radix-2 division step: shift in a bit, conditionally subtract.
module mwd_div_step (
    input  logic [mwd_pkg::WORD_BITS-1:0] rem_in,
    input  logic                          bit_in,
    input  logic [mwd_pkg::WORD_BITS-1:0] divisor,
    output mwd_pkg::step_res_t            res
);
    import mwd_pkg::*;

    logic [WORD_BITS-1:0] shifted;
    logic [WORD_BITS:0]   diff;
    logic                 qbit;

    assign shifted = {rem_in[WORD_BITS-2:0], bit_in};
    // The bit shifted out on top makes the partial remainder one bit wider
    assign diff    = {rem_in[WORD_BITS-1], shifted} - {1'b0, divisor};
    assign qbit    = ~diff[WORD_BITS];
    assign res     = {qbit, qbit ? diff[WORD_BITS-1:0] : shifted};

endmodule
